// ===== rtl/core/rtt_estimator_rto_top_defines.svh =====
// Assertion macros used by the checker file of the RTO estimator.
`ifndef RTT_ESTIMATOR_RTO_TOP_DEFINES_SVH
`define RTT_ESTIMATOR_RTO_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RTTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rtte_pkg.sv =====
`default_nettype none
package rtte_pkg;

  localparam logic [8:0] GAIN_ONE = 9'd256;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_BETA = 3'd1;
  localparam logic [2:0] REG_VAR_MULT = 3'd2;
  localparam logic [2:0] REG_GRANULARITY = 3'd3;
  localparam logic [2:0] REG_RTO_FLOOR = 3'd4;
  localparam logic [2:0] REG_RTO_CEILING = 3'd5;

  localparam logic [8:0] ALPHA_RESET = 9'd32;
  localparam logic [8:0] BETA_RESET = 9'd64;
  localparam logic [3:0] VAR_MULT_RESET = 4'd4;
  localparam logic [15:0] GRANULARITY_RESET = 16'd1;
  localparam logic [15:0] RTO_FLOOR_RESET = 16'd200;
  localparam logic [15:0] RTO_CEILING_RESET = 16'd60000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_VAR_OLD,
    ST_VAR_NEW,
    ST_SRTT_OLD,
    ST_SRTT_NEW,
    ST_TERM,
    ST_SUM,
    ST_CLAMP
  } state_t;

  typedef enum logic [2:0] {
    OP_VAR_OLD,
    OP_VAR_NEW,
    OP_SRTT_OLD,
    OP_SRTT_NEW,
    OP_TERM
  } mac_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    mac_en;
    mac_op_t mac_op;
    logic    init_load;
    logic    var_load;
    logic    srtt_load;
    logic    sum_load;
    logic    out_load;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/rtte_mac.sv =====
`default_nettype none
// Shared multiply-accumulate unit: res = (acc or zero) + a * b.
module rtte_mac (
  input  wire                logic clk,
  input  wire                logic en,
  input  wire rtte_pkg::mac_op_t op,
  input  wire                logic [15:0] var_q,
  input  wire                logic [15:0] diff,
  input  wire                logic [15:0] srtt,
  input  wire                logic [15:0] sample,
  input  wire                logic [8:0]  alpha_sat,
  input  wire                logic [8:0]  beta_sat,
  input  wire                logic [3:0]  k,
  output logic [24:0] res,
  output logic [24:0] acc
);

  logic [8:0]  a_op;
  logic [15:0] b_op;
  logic        add_acc;
  logic [24:0] prod;

  always_comb begin
    a_op = '0;
    b_op = '0;
    add_acc = 1'b0;
    case (op)
      rtte_pkg::OP_VAR_OLD: begin
        a_op = 9'(rtte_pkg::GAIN_ONE - beta_sat);
        b_op = var_q;
      end
      rtte_pkg::OP_VAR_NEW: begin
        a_op = beta_sat;
        b_op = diff;
        add_acc = 1'b1;
      end
      rtte_pkg::OP_SRTT_OLD: begin
        a_op = 9'(rtte_pkg::GAIN_ONE - alpha_sat);
        b_op = srtt;
      end
      rtte_pkg::OP_SRTT_NEW: begin
        a_op = alpha_sat;
        b_op = sample;
        add_acc = 1'b1;
      end
      rtte_pkg::OP_TERM: begin
        a_op = {5'd0, k};
        b_op = var_q;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod = 25'(a_op) * 25'(b_op);
  assign res = (add_acc ? acc : 25'd0) + prod;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rtte_seq.sv =====
`default_nettype none
// Sequencer that steps the shared unit through one sample update.
module rtte_seq (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  input  wire  logic srtt_zero,
  input  wire  logic out_free,
  output rtte_pkg::ctrl_t ctrl
);

  rtte_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rtte_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = srtt_zero ? rtte_pkg::ST_INIT : rtte_pkg::ST_VAR_OLD;
        end
      end
      rtte_pkg::ST_INIT:     state_next = rtte_pkg::ST_TERM;
      rtte_pkg::ST_VAR_OLD:  state_next = rtte_pkg::ST_VAR_NEW;
      rtte_pkg::ST_VAR_NEW:  state_next = rtte_pkg::ST_SRTT_OLD;
      rtte_pkg::ST_SRTT_OLD: state_next = rtte_pkg::ST_SRTT_NEW;
      rtte_pkg::ST_SRTT_NEW: state_next = rtte_pkg::ST_TERM;
      rtte_pkg::ST_TERM:     state_next = rtte_pkg::ST_SUM;
      rtte_pkg::ST_SUM:      state_next = rtte_pkg::ST_CLAMP;
      rtte_pkg::ST_CLAMP: begin
        if (out_free) begin
          state_next = rtte_pkg::ST_IDLE;
        end
      end
      default: state_next = rtte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mac_op = rtte_pkg::OP_TERM;
    case (state)
      rtte_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      rtte_pkg::ST_INIT: ctrl.init_load = 1'b1;
      rtte_pkg::ST_VAR_OLD: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = rtte_pkg::OP_VAR_OLD;
      end
      rtte_pkg::ST_VAR_NEW: begin
        ctrl.mac_op = rtte_pkg::OP_VAR_NEW;
        ctrl.var_load = 1'b1;
      end
      rtte_pkg::ST_SRTT_OLD: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = rtte_pkg::OP_SRTT_OLD;
      end
      rtte_pkg::ST_SRTT_NEW: begin
        ctrl.mac_op = rtte_pkg::OP_SRTT_NEW;
        ctrl.srtt_load = 1'b1;
      end
      rtte_pkg::ST_TERM: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = rtte_pkg::OP_TERM;
      end
      rtte_pkg::ST_SUM: ctrl.sum_load = 1'b1;
      rtte_pkg::ST_CLAMP: ctrl.out_load = out_free;
      default: ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rtt_estimator_rto_top.sv =====
// Retransmission timeout estimator after the usual smoothed RTT / variance scheme.
// Input channel (s_tvalid, s_tready, s_tdata) carries one RTT sample in ms per beat.
// Output channel (m_tvalid, m_tready, m_tdata) returns one beat per sample with the
// clamped RTO, the updated smoothed RTT and the updated RTT variance.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// gains, the variance multiplier, the granularity and the RTO floor and ceiling.
// It should only be written while no sample is in flight.
// A sample passes from its input beat to its output beat through the states VAR_OLD,
// VAR_NEW, SRTT_OLD, SRTT_NEW, TERM, SUM and CLAMP, or through INIT, TERM, SUM and
// CLAMP when the stored smoothed RTT is zero and the sample is taken as the first.
// The single shared multiply-accumulate unit forms the two products of each average
// and the variance term one after the other under a small sequencer. The input is
// not ready while a sample is being worked on, so one sample is taken at a time.
// A finished result waits in an output register; the input is ready again while it
// waits. If the receiver keeps stalling, the next sample stops at its last step until
// the output register is free, so no result is lost or overwritten.
// Reset is synchronous and active high. It clears the smoothed RTT and the variance,
// restores every configuration register to its default, drops the output beat and
// holds both ready signals low while it is asserted.
`default_nettype none
module rtt_estimator_rto_top (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [15:0] s_tdata,   // [15:0] rtt_sample_ms
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [47:0]       m_tdata,   // [15:0] rto_ms, [31:16] smoothed_rtt_ms,
                                       // [47:32] rtt_variance_ms
  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic [2:0]  cfg_index,
  input  wire  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [8:0]  alpha_q8;
  logic [8:0]  beta_q8;
  logic [3:0]  var_multiplier;
  logic [15:0] clock_granularity_ms;
  logic [15:0] rto_floor_ms;
  logic [15:0] rto_ceiling_ms;

  // Estimator state and per-sample working registers.
  logic [15:0] smoothed_rtt;
  logic [15:0] rtt_variance;
  logic [15:0] sample;
  logic [15:0] diff;
  logic [20:0] rto_sum;

  rtte_pkg::ctrl_t ctrl;
  logic        in_accept;
  logic        out_free;
  logic [8:0]  alpha_sat;
  logic [8:0]  beta_sat;
  logic [24:0] mac_res;
  logic [24:0] mac_acc;
  logic [20:0] var_term;
  logic [20:0] rto_low;
  logic [20:0] rto_clamped;

  assign cfg_ready = !rst;
  assign s_tready = ctrl.in_ready && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Gains above one are taken as exactly one so the averages stay in 16 bits.
  assign alpha_sat = (alpha_q8 > rtte_pkg::GAIN_ONE) ? rtte_pkg::GAIN_ONE : alpha_q8;
  assign beta_sat = (beta_q8 > rtte_pkg::GAIN_ONE) ? rtte_pkg::GAIN_ONE : beta_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8 <= rtte_pkg::ALPHA_RESET;
      beta_q8 <= rtte_pkg::BETA_RESET;
      var_multiplier <= rtte_pkg::VAR_MULT_RESET;
      clock_granularity_ms <= rtte_pkg::GRANULARITY_RESET;
      rto_floor_ms <= rtte_pkg::RTO_FLOOR_RESET;
      rto_ceiling_ms <= rtte_pkg::RTO_CEILING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtte_pkg::REG_ALPHA:       alpha_q8 <= cfg_data[8:0];
        rtte_pkg::REG_BETA:        beta_q8 <= cfg_data[8:0];
        rtte_pkg::REG_VAR_MULT:    var_multiplier <= cfg_data[3:0];
        rtte_pkg::REG_GRANULARITY: clock_granularity_ms <= cfg_data;
        rtte_pkg::REG_RTO_FLOOR:   rto_floor_ms <= cfg_data;
        rtte_pkg::REG_RTO_CEILING: rto_ceiling_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  rtte_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .srtt_zero (smoothed_rtt == 16'd0),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  rtte_mac u_mac (
    .clk       (clk),
    .en        (ctrl.mac_en),
    .op        (ctrl.mac_op),
    .var_q     (rtt_variance),
    .diff      (diff),
    .srtt      (smoothed_rtt),
    .sample    (sample),
    .alpha_sat (alpha_sat),
    .beta_sat  (beta_sat),
    .k         (var_multiplier),
    .res       (mac_res),
    .acc       (mac_acc)
  );

  // The sample and its distance from the old smoothed RTT are captured on the input
  // beat, so both averages below see the values from before this update.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample <= s_tdata;
      diff <= (smoothed_rtt > s_tdata) ? (smoothed_rtt - s_tdata) : (s_tdata - smoothed_rtt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_rtt <= '0;
      rtt_variance <= '0;
    end else if (ctrl.init_load) begin
      smoothed_rtt <= sample;
      rtt_variance <= {1'b0, sample[15:1]};
    end else begin
      if (ctrl.var_load) begin
        rtt_variance <= mac_res[23:8];
      end
      if (ctrl.srtt_load) begin
        smoothed_rtt <= mac_res[23:8];
      end
    end
  end

  // K * RTTVAR is below 2^20, so the low 21 bits of the accumulator hold it whole.
  assign var_term = (mac_acc[20:0] > 21'(clock_granularity_ms)) ?
                    mac_acc[20:0] : 21'(clock_granularity_ms);

  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      rto_sum <= 21'(smoothed_rtt) + var_term;
    end
  end

  // Floor first, then ceiling, so the ceiling wins when the two cross.
  assign rto_low = (rto_sum < 21'(rto_floor_ms)) ? 21'(rto_floor_ms) : rto_sum;
  assign rto_clamped = (rto_low > 21'(rto_ceiling_ms)) ? 21'(rto_ceiling_ms) : rto_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {rtt_variance, smoothed_rtt, rto_clamped[15:0]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rtte_checker.sv =====
`default_nettype none
`include "rtt_estimator_rto_top_defines.svh"
// Port-level checks for the RTO estimator.
module rtte_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  // A stalled result beat stays up with the same data.
  `RTTE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

  // The block works on one sample at a time.
  `RTTE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after a beat")

  // A new result appears only at the end of the work on a sample.
  `RTTE_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

endmodule

bind rtt_estimator_rto_top rtte_checker u_rtte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
